/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/aes_pkg.sv */
`timescale 1ns / 1ps
package aes_pkg;

   typedef struct packed {
      logic [63:0] state_hi;
      logic [63:0] state_lo;
      logic [63:0] key_hi;
      logic [63:0] key_lo;
   } req_type;

   typedef struct packed {
      logic [63:0] result_hi;
      logic [63:0] result_lo;
   } rsp_type;

   localparam int NumCols = 4;
   localparam logic [7:0] GfPoly = 8'h1b;

   // Standard forward S-box.
   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Multiply by two in GF(2^8).
   function automatic logic [7:0] xtime(input logic [7:0] a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? GfPoly : 8'h00);
   endfunction

endpackage

/* rtl/core/aes_col_lane.sv */
`timescale 1ns / 1ps
// One column lane: S-box on four bytes, then MixColumns.
module aes_col_lane
   import aes_pkg::*;
(
   input  logic [31:0] col_in,
   output logic [31:0] col_out
);

   logic [7:0] a0, a1, a2, a3;

   // Substitute each byte; byte 0 sits in the top bits.
   assign a0 = SBOX[col_in[31:24]];
   assign a1 = SBOX[col_in[23:16]];
   assign a2 = SBOX[col_in[15:8]];
   assign a3 = SBOX[col_in[7:0]];

   // Circulant 2,3,1,1 mix; times three is times two XOR the byte.
   assign col_out[31:24] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
   assign col_out[23:16] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
   assign col_out[15:8]  = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
   assign col_out[7:0]   = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);

endmodule

/* rtl/core/aes_encrypt_round.sv */
`timescale 1ns / 1ps
// Channel | Direction | Payload
// req_    | in        | state_hi, state_lo, key_hi, key_lo
// rsp_    | out       | result_hi, result_lo
//
// One item per cycle while the output is not stalled; the result shows in the cycle after the item is accepted.
// Four column lanes work in parallel; the merge stage adds the round key and
// registers the result, which holds until taken.
// req_ready is high when the output register is empty or is being taken.
// Reset clears the output valid; nothing else is held.
module aes_encrypt_round
   import aes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [127:0] st;
   logic [127:0] key;
   logic [127:0] shifted;
   logic [127:0] mixed;
   logic         valid_ff, valid_in;
   rsp_type      data_ff, data_in;

   assign st  = {req_data.state_hi, req_data.state_lo};
   assign key = {req_data.key_hi, req_data.key_lo};

   // ShiftRows as wiring: output byte i takes input byte (5*i) mod 16.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         shifted[127 - 8*i -: 8] = st[127 - 8*((i*5) % 16) -: 8];
      end
   end

   // One lane per column.
   for (genvar c = 0; c < NumCols; c++) begin : g_lane
      aes_col_lane u_lane (
         .col_in  (shifted[127 - 32*c -: 32]),
         .col_out (mixed[127 - 32*c -: 32])
      );
   end

   // Merge lanes with the round key into the output register.
   assign req_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (req_ready) begin
         valid_in = req_valid;
         data_in  = mixed ^ key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/core/aes_round_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Port-level checks on the round block.
module aes_round_props
   import aes_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // An accepted item shows a result in the next cycle.
   `ASSERT_NEXT(a_lat, clock, reset, req_valid && req_ready, rsp_valid, "result missing")

   // A stalled result holds its data.
   `ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // The block takes an item whenever its output is empty.
   `ASSERT_IMPL(a_rdy, clock, reset, !rsp_valid, req_ready, "ready low while empty")

   // No result appears without an accepted item.
   `ASSERT_NEXT(a_none, clock, reset, !(req_valid && req_ready) && !rsp_valid, !rsp_valid, "spurious result")

endmodule

bind aes_encrypt_round aes_round_props u_checker (.*);
